/* rtl/nbc_pkg.sv */
// Shared constants and types for the polygon normal and back-face cull block.
package nbc_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;

    // Normalisation works on component magnitudes held below 2^30
    localparam int CMAG_WIDTH = 30;
    localparam int LEN_WIDTH  = 2 * CMAG_WIDTH + 2;
    localparam int ROOT_WIDTH = LEN_WIDTH / 2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_VIEW_X = 2'd0,
        REG_VIEW_Y = 2'd1,
        REG_VIEW_Z = 2'd2
    } reg_index_t;

    // Per-transaction flags that travel beside the data
    typedef struct packed {
        logic       valid;
        logic       visible;
        logic       degenerate;
        logic [2:0] neg;
    } tag_t;

endpackage

/* rtl/nbc_front.sv */
// Front pipeline: edge vectors, cross product, view dot product, scaling and squared length.
module nbc_front #(
    parameter int COORD_WIDTH = nbc_pkg::COORD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [COORD_WIDTH-1:0]        vtx_a [0:2],
    input  logic signed [COORD_WIDTH-1:0]        vtx_b [0:2],
    input  logic signed [COORD_WIDTH-1:0]        vtx_c [0:2],
    input  logic signed [COORD_WIDTH-1:0]        view_ref [0:2],
    output nbc_pkg::tag_t                        tag_out,
    output logic [nbc_pkg::CMAG_WIDTH-1:0]       cmag_out [0:2],
    output logic [nbc_pkg::LEN_WIDTH-1:0]        len_sq_out
);

    localparam int DIFW = COORD_WIDTH + 1;
    localparam int PW   = 2 * DIFW;
    localparam int NFW  = 2 * COORD_WIDTH + 3;
    localparam int NW   = (NFW > 64) ? 64 : NFW;
    localparam int DPW  = DIFW + NW;
    localparam int DW   = (DPW + 2 > 64) ? 64 : DPW + 2;
    localparam int CMW  = nbc_pkg::CMAG_WIDTH;
    localparam int SHN  = (NW > CMW) ? NW - CMW : 0;
    localparam int SW   = $clog2(SHN + 2);
    localparam int LW   = nbc_pkg::LEN_WIDTH;

    // valid bits for stages 1..7
    logic [7:1] vld_reg;

    logic signed [DIFW-1:0] u1_reg [0:2];
    logic signed [DIFW-1:0] w1_reg [0:2];
    logic signed [DIFW-1:0] d1_reg [0:2];
    logic signed [PW-1:0]   p1_reg [0:2];
    logic signed [PW-1:0]   p2_reg [0:2];
    logic signed [DIFW-1:0] d2_reg [0:2];
    logic signed [NW-1:0]   n3_reg [0:2];
    logic signed [DIFW-1:0] d3_reg [0:2];
    logic signed [DPW-1:0]  dp4_reg [0:2];
    logic [NW-1:0]          mag4_reg [0:2];
    logic [2:0]             neg4_reg;
    logic                   deg4_reg;
    logic [NW-1:0]          mag5_reg [0:2];
    logic [SW-1:0]          shift5_reg;
    logic [SW-1:0]          shift_next;
    logic signed [DW-1:0]   dot;
    logic [NW-1:0]          mag_or;
    logic [2:0]             neg5_reg;
    logic                   deg5_reg;
    logic                   vis5_reg;
    logic [CMW-1:0]         c6_reg [0:2];
    logic [CMW-1:0]         c7_reg [0:2];
    logic [2*CMW-1:0]       sq7_reg [0:2];
    nbc_pkg::tag_t          tag6_reg;
    nbc_pkg::tag_t          tag7_reg;
    nbc_pkg::tag_t          tag_reg;
    logic [CMW-1:0]         c8_reg [0:2];
    logic [LW-1:0]          len_reg;

    // Valid shift line and output flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            tag_reg.valid <= 1'b0;
        end
        else
        begin
            vld_reg            <= {vld_reg[6:1], in_valid};
            tag_reg.valid      <= vld_reg[7];
            tag_reg.visible    <= tag7_reg.visible;
            tag_reg.degenerate <= tag7_reg.degenerate;
            tag_reg.neg        <= tag7_reg.neg;
        end
    end

    // View dot product and normal-wide OR for the shift search
    always_comb
    begin
        dot    = DW'(dp4_reg[0]) + DW'(dp4_reg[1]) + DW'(dp4_reg[2]);
        mag_or = mag4_reg[0] | mag4_reg[1] | mag4_reg[2];
        shift_next = '0;
        for (int k = 1; k <= SHN; k++)
        begin
            if ((mag_or >> (CMW + k - 1)) != '0)
                shift_next = shift_next + SW'(1);
        end
    end

    genvar i;
    generate
        for (i = 0; i < 3; i++)
        begin : g_comp
            localparam int J = (i + 1) % 3;
            localparam int K = (i + 2) % 3;

            always_ff @(posedge clk)
            begin
                // stage 1: edges and view direction
                u1_reg[i]  <= DIFW'(vtx_b[i]) - DIFW'(vtx_a[i]);
                w1_reg[i]  <= DIFW'(vtx_c[i]) - DIFW'(vtx_a[i]);
                d1_reg[i]  <= DIFW'(view_ref[i]) - DIFW'(vtx_a[i]);
                // stage 2: cross-product terms
                p1_reg[i]  <= u1_reg[J] * w1_reg[K];
                p2_reg[i]  <= u1_reg[K] * w1_reg[J];
                d2_reg[i]  <= d1_reg[i];
                // stage 3: normal component
                n3_reg[i]  <= NW'(NFW'(p1_reg[i]) - NFW'(p2_reg[i]));
                d3_reg[i]  <= d2_reg[i];
                // stage 4: dot terms and magnitudes
                dp4_reg[i] <= d3_reg[i] * n3_reg[i];
                mag4_reg[i] <= n3_reg[i][NW-1] ? NW'(-n3_reg[i]) : NW'(n3_reg[i]);
                neg4_reg[i] <= n3_reg[i][NW-1];
                // stage 5
                mag5_reg[i] <= mag4_reg[i];
                // stage 6: scale into 30 bits
                c6_reg[i]  <= CMW'(64'(mag5_reg[i]) >> shift5_reg);
                // stage 7: squares
                sq7_reg[i] <= c6_reg[i] * c6_reg[i];
                c7_reg[i]  <= c6_reg[i];
                // stage 8
                c8_reg[i]  <= c7_reg[i];
            end

            assign cmag_out[i] = c8_reg[i];
        end
    endgenerate

    // Flag payload
    always_ff @(posedge clk)
    begin
        deg4_reg   <= (n3_reg[0] == '0) && (n3_reg[1] == '0) && (n3_reg[2] == '0);
        neg5_reg   <= neg4_reg;
        deg5_reg   <= deg4_reg;
        vis5_reg   <= (dot > 0);
        shift5_reg <= shift_next;

        tag6_reg.valid      <= 1'b0;
        tag6_reg.visible    <= vis5_reg;
        tag6_reg.degenerate <= deg5_reg;
        tag6_reg.neg        <= neg5_reg;
        tag7_reg            <= tag6_reg;

        len_reg <= LW'(sq7_reg[0]) + LW'(sq7_reg[1]) + LW'(sq7_reg[2]);
    end

    assign tag_out    = tag_reg;
    assign len_sq_out = len_reg;

    // a degenerate normal has no magnitude left after scaling
    assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg.valid && tag_reg.degenerate |-> len_reg == '0)
        else $error("degenerate normal with nonzero length");
    // a real normal keeps a nonzero squared length
    assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg.valid && !tag_reg.degenerate |-> len_reg != '0)
        else $error("nonzero normal lost in scaling");
    // shifting never hides the top bits of the largest magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |=> (c6_reg[0] | c6_reg[1] | c6_reg[2]) != '0 || tag6_reg.degenerate)
        else $error("scaled magnitudes all zero");

endmodule

/* rtl/nbc_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
module nbc_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nbc_pkg::tag_t                   tag_in,
    input  logic [nbc_pkg::CMAG_WIDTH-1:0]  cmag_in [0:2],
    input  logic [nbc_pkg::LEN_WIDTH-1:0]   len_sq_in,
    output nbc_pkg::tag_t                   tag_out,
    output logic [nbc_pkg::CMAG_WIDTH-1:0]  cmag_out [0:2],
    output logic [nbc_pkg::ROOT_WIDTH-1:0]  root_out
);

    localparam int RW   = nbc_pkg::ROOT_WIDTH;
    localparam int LW   = nbc_pkg::LEN_WIDTH;
    localparam int CMW  = nbc_pkg::CMAG_WIDTH;
    localparam int REMW = RW + 2;

    logic [RW-1:0]    root_reg [0:RW-1];
    logic [REMW-1:0]  rem_reg  [0:RW-1];
    logic [LW-1:0]    len_reg  [0:RW-1];
    logic [CMW-1:0]   c_reg    [0:RW-1][0:2];
    nbc_pkg::tag_t    tag_reg  [0:RW-1];

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_stage
            localparam int P = RW - 1 - k;
            logic [RW-1:0]    root_prev;
            logic [REMW-1:0]  rem_prev;
            logic [LW-1:0]    len_prev;
            logic [CMW-1:0]   c_prev [0:2];
            nbc_pkg::tag_t    tag_prev;
            logic [REMW+1:0]  trial_rem;
            logic [REMW+1:0]  trial_sub;
            logic             take;

            if (k == 0)
            begin : g_first
                assign root_prev = '0;
                assign rem_prev  = '0;
                assign len_prev  = len_sq_in;
                assign c_prev    = cmag_in;
                assign tag_prev  = tag_in;
            end
            else
            begin : g_next
                assign root_prev = root_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign len_prev  = len_reg[k-1];
                assign c_prev    = c_reg[k-1];
                assign tag_prev  = tag_reg[k-1];
            end

            // bring down two bits, try (2*root)*2 + 1
            always_comb
            begin
                trial_rem = {rem_prev, len_prev[2*P+1 -: 2]};
                trial_sub = (REMW + 2)'({root_prev, 2'b01});
                take      = (trial_rem >= trial_sub);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    tag_reg[k].valid <= 1'b0;
                else
                    tag_reg[k] <= tag_prev;
            end

            always_ff @(posedge clk)
            begin
                root_reg[k] <= {root_prev[RW-2:0], take};
                rem_reg[k]  <= take ? REMW'(trial_rem - trial_sub) : REMW'(trial_rem);
                len_reg[k]  <= len_prev;
                c_reg[k]    <= c_prev;
            end
        end
    endgenerate

    assign root_out = root_reg[RW-1];
    assign cmag_out = c_reg[RW-1];
    assign tag_out  = tag_reg[RW-1];

    // the root is never below any component that fed it, i.e. root >= each component
    assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg[RW-1].valid |-> root_reg[RW-1] >= RW'(c_reg[RW-1][0])
            && root_reg[RW-1] >= RW'(c_reg[RW-1][1])
            && root_reg[RW-1] >= RW'(c_reg[RW-1][2]))
        else $error("root below a component magnitude");
    // final remainder bounded by twice the root
    assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg[RW-1].valid |-> rem_reg[RW-1] <= REMW'({root_reg[RW-1], 1'b0}))
        else $error("square root remainder out of range");
    // valid travels through every stage
    assert property (@(posedge clk) disable iff (!rst_n)
        tag_in.valid |-> ##(RW) tag_reg[RW-1].valid)
        else $error("transaction lost in square root pipeline");

endmodule

/* rtl/nbc_div.sv */
// Pipelined rounding divider for the three components and output formatting.
module nbc_div #(
    parameter int NORMAL_FRAC_BITS = nbc_pkg::NORMAL_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nbc_pkg::tag_t                       tag_in,
    input  logic [nbc_pkg::CMAG_WIDTH-1:0]      cmag_in [0:2],
    input  logic [nbc_pkg::ROOT_WIDTH-1:0]      root_in,
    output logic                                out_valid,
    output logic signed [NORMAL_FRAC_BITS+1:0]  normal_out [0:2],
    output logic                                visible_out,
    output logic                                degenerate_out
);

    localparam int F    = NORMAL_FRAC_BITS;
    localparam int QW   = F + 1;
    localparam int OW   = F + 2;
    localparam int RW   = nbc_pkg::ROOT_WIDTH;
    localparam int CMW  = nbc_pkg::CMAG_WIDTH;
    localparam int NUMW = CMW + F + 1;
    localparam int REMW = RW + 1;
    localparam logic [QW-1:0] ONE = QW'(1) << F;

    logic [RW-1:0]    div_reg [0:QW];
    logic [REMW-1:0]  rem_reg [0:QW][0:2];
    logic [QW-1:0]    lo_reg  [0:QW][0:2];
    logic [QW-1:0]    q_reg   [0:QW][0:2];
    nbc_pkg::tag_t    tag_reg [0:QW];
    logic [RW-1:0]    divisor;
    logic [OW-1:0]    nrm_reg [0:2];
    logic             vld_reg;
    logic             vis_reg;
    logic             deg_reg;

    // zero root only for a degenerate normal; keep the divisor nonzero
    assign divisor = (root_in == '0) ? RW'(1) : root_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0].valid <= 1'b0;
            vld_reg          <= 1'b0;
        end
        else
        begin
            tag_reg[0] <= tag_in;
            vld_reg    <= tag_reg[QW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg[0] <= divisor;
        vis_reg    <= tag_reg[QW].visible && !tag_reg[QW].degenerate;
        deg_reg    <= tag_reg[QW].degenerate;
    end

    genvar i, j;
    generate
        for (i = 0; i < 3; i++)
        begin : g_comp
            logic [NUMW-1:0] num;
            logic [QW-1:0]   q_sat;

            // numerator with half the divisor added for rounding
            assign num = (NUMW'(cmag_in[i]) << F) + NUMW'(divisor >> 1);

            always_ff @(posedge clk)
            begin
                rem_reg[0][i] <= REMW'(num >> QW);
                lo_reg[0][i]  <= num[QW-1:0];
                q_reg[0][i]   <= '0;
            end

            // saturate, apply sign, clear when degenerate
            assign q_sat = (q_reg[QW][i] > ONE) ? ONE : q_reg[QW][i];

            always_ff @(posedge clk)
            begin
                if (tag_reg[QW].degenerate)
                    nrm_reg[i] <= '0;
                else if (tag_reg[QW].neg[i])
                    nrm_reg[i] <= OW'(-OW'(q_sat));
                else
                    nrm_reg[i] <= OW'(q_sat);
            end

            assign normal_out[i] = signed'(nrm_reg[i]);
        end

        // one quotient bit per stage
        for (j = 1; j <= QW; j++)
        begin : g_step
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    tag_reg[j].valid <= 1'b0;
                else
                    tag_reg[j] <= tag_reg[j-1];
            end

            always_ff @(posedge clk)
            begin
                div_reg[j] <= div_reg[j-1];
            end

            for (i = 0; i < 3; i++)
            begin : g_lane
                logic [REMW:0] t;
                logic          take;

                always_comb
                begin
                    t    = {rem_reg[j-1][i], lo_reg[j-1][i][QW-j]};
                    take = (t >= (REMW + 1)'(div_reg[j-1]));
                end

                always_ff @(posedge clk)
                begin
                    rem_reg[j][i] <= take ? REMW'(t - (REMW + 1)'(div_reg[j-1])) : REMW'(t);
                    lo_reg[j][i]  <= lo_reg[j-1][i];
                    q_reg[j][i]   <= {q_reg[j-1][i][QW-2:0], take};
                end
            end
        end
    endgenerate

    assign out_valid      = vld_reg;
    assign visible_out    = vis_reg;
    assign degenerate_out = deg_reg;

    // partial remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg[QW].valid |-> REMW'(div_reg[QW]) > rem_reg[QW][0])
        else $error("divider remainder not reduced");
    // quotient of a unit-vector component never passes one
    assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg[QW].valid && !tag_reg[QW].degenerate |-> q_reg[QW][0] <= ONE
            && q_reg[QW][1] <= ONE && q_reg[QW][2] <= ONE)
        else $error("normal component above one");
    // valid travels through every stage
    assert property (@(posedge clk) disable iff (!rst_n)
        tag_in.valid |-> ##(QW + 2) vld_reg)
        else $error("transaction lost in divider");

endmodule

/* rtl/polygon_normal_backface_cull.sv */
// Top level of the polygon normal and back-face cull block.
// One polygon transaction is taken on every clock at which start is high (busy is held
// low); its result appears on the result ports with done high, one result per
// transaction, in order. The pipeline is an 8-stage front end (edge vectors, cross
// product, dot product, scaling, squared length), a 31-stage square root that resolves
// one root bit per stage, and a divider that resolves one quotient bit per stage for
// all three components in parallel plus an input and an output register.
// Results cannot be held off: done is a one-cycle strobe. The view reference point is
// written through cfg_write/cfg_index/cfg_data; write it only while no polygon is in flight.
module polygon_normal_backface_cull #(
    parameter int COORD_WIDTH      = nbc_pkg::COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = nbc_pkg::NORMAL_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       first_x,
    input  logic signed [COORD_WIDTH-1:0]       first_y,
    input  logic signed [COORD_WIDTH-1:0]       first_z,
    input  logic signed [COORD_WIDTH-1:0]       second_x,
    input  logic signed [COORD_WIDTH-1:0]       second_y,
    input  logic signed [COORD_WIDTH-1:0]       second_z,
    input  logic signed [COORD_WIDTH-1:0]       third_x,
    input  logic signed [COORD_WIDTH-1:0]       third_y,
    input  logic signed [COORD_WIDTH-1:0]       third_z,
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data,
    output logic                                done,
    output logic signed [NORMAL_FRAC_BITS+1:0]  normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0]  normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0]  normal_z,
    output logic                                visible,
    output logic                                degenerate
);

    localparam int LATENCY = NORMAL_FRAC_BITS + 42;
    localparam int OW      = NORMAL_FRAC_BITS + 2;
    localparam logic signed [OW-1:0] ONE_POS = OW'(1) << NORMAL_FRAC_BITS;
    localparam logic signed [OW-1:0] ONE_NEG = -(OW'(1) << NORMAL_FRAC_BITS);

    logic signed [COORD_WIDTH-1:0] view_reg [0:2];
    logic signed [COORD_WIDTH-1:0] vtx_a [0:2];
    logic signed [COORD_WIDTH-1:0] vtx_b [0:2];
    logic signed [COORD_WIDTH-1:0] vtx_c [0:2];
    logic                          accept;

    nbc_pkg::tag_t                  front_tag;
    logic [nbc_pkg::CMAG_WIDTH-1:0] front_cmag [0:2];
    logic [nbc_pkg::LEN_WIDTH-1:0]  front_len;
    nbc_pkg::tag_t                  sqrt_tag;
    logic [nbc_pkg::CMAG_WIDTH-1:0] sqrt_cmag [0:2];
    logic [nbc_pkg::ROOT_WIDTH-1:0] sqrt_root;
    logic signed [OW-1:0]           nrm [0:2];

    // fully pipelined: never busy
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // View reference registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_reg[0] <= '0;
            view_reg[1] <= '0;
            view_reg[2] <= '0;
        end
        else if (cfg_write)
        begin
            unique case (nbc_pkg::reg_index_t'(cfg_index))
                nbc_pkg::REG_VIEW_X: view_reg[0] <= signed'(cfg_data);
                nbc_pkg::REG_VIEW_Y: view_reg[1] <= signed'(cfg_data);
                nbc_pkg::REG_VIEW_Z: view_reg[2] <= signed'(cfg_data);
                default:    ;
            endcase
        end
    end

    assign vtx_a = '{first_x, first_y, first_z};
    assign vtx_b = '{second_x, second_y, second_z};
    assign vtx_c = '{third_x, third_y, third_z};

    nbc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .vtx_a      (vtx_a),
        .vtx_b      (vtx_b),
        .vtx_c      (vtx_c),
        .view_ref   (view_reg),
        .tag_out    (front_tag),
        .cmag_out   (front_cmag),
        .len_sq_out (front_len)
    );

    nbc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (front_tag),
        .cmag_in   (front_cmag),
        .len_sq_in (front_len),
        .tag_out   (sqrt_tag),
        .cmag_out  (sqrt_cmag),
        .root_out  (sqrt_root)
    );

    nbc_div #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_div (
        .clk            (clk),
        .rst_n          (rst_n),
        .tag_in         (sqrt_tag),
        .cmag_in        (sqrt_cmag),
        .root_in        (sqrt_root),
        .out_valid      (done),
        .normal_out     (nrm),
        .visible_out    (visible),
        .degenerate_out (degenerate)
    );

    assign normal_x = nrm[0];
    assign normal_y = nrm[1];
    assign normal_z = nrm[2];

    // every accepted transaction comes out after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LATENCY) done)
        else $error("result missing after pipeline latency");
    // no result without a matching transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a transaction");
    // degenerate result is zero and culled
    assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> !visible && normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("degenerate result not cleared");
    // components stay within plus and minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> normal_x <= ONE_POS && normal_x >= ONE_NEG
            && normal_y <= ONE_POS && normal_y >= ONE_NEG
            && normal_z <= ONE_POS && normal_z >= ONE_NEG)
        else $error("normal component out of range");

endmodule

/* sim/polygon_normal_backface_cull_tb.sv */
// Self-checking testbench for the polygon normal and back-face cull block.
module polygon_normal_backface_cull_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = nbc_pkg::NORMAL_FRAC_BITS + 2;
    localparam int PIPE_DEPTH = nbc_pkg::NORMAL_FRAC_BITS + 42;

    // Index with no register behind it
    localparam logic [1:0] REG_NONE   = 2'd3;

    typedef logic signed [nbc_pkg::COORD_WIDTH-1:0] coord_t;

    typedef struct {
        coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
    } poly_t;

    typedef struct {
        logic signed [NW-1:0] nx, ny, nz;
        logic vis, degen;
    } cull_t;

    logic clk, rst_n, start, busy, cfg_write, done;
    logic [1:0] cfg_index;
    logic [nbc_pkg::COORD_WIDTH-1:0] cfg_data;
    coord_t first_x, first_y, first_z, second_x, second_y, second_z;
    coord_t third_x, third_y, third_z;
    logic signed [NW-1:0] normal_x, normal_y, normal_z;
    logic visible, degenerate;

    poly_t polys_pending[$];
    cull_t cull_expected[$];
    coord_t eye_x, eye_y, eye_z;
    poly_t cur_poly;
    int gap_left;
    bit no_idle;
    int n_errors;

    polygon_normal_backface_cull u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .first_x(first_x), .first_y(first_y), .first_z(first_z),
        .second_x(second_x), .second_y(second_y), .second_z(second_z),
        .third_x(third_x), .third_y(third_y), .third_z(third_z),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .visible(visible), .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Unit normal and facing of one polygon under the current view point
    function automatic cull_t cull_predict(poly_t p);
        longint ux, uy, uz, vx, vy, vz, dot;
        longint n[3];
        longint unsigned mag[3];
        longint unsigned mx, len2, r, q;
        logic signed [NW-1:0] o[3];
        int s;
        cull_t res;
        ux = longint'(p.bx) - longint'(p.ax);
        uy = longint'(p.by) - longint'(p.ay);
        uz = longint'(p.bz) - longint'(p.az);
        vx = longint'(p.cx) - longint'(p.ax);
        vy = longint'(p.cy) - longint'(p.ay);
        vz = longint'(p.cz) - longint'(p.az);
        n[0] = uy * vz - uz * vy;
        n[1] = uz * vx - ux * vz;
        n[2] = ux * vy - uy * vx;
        dot = (longint'(eye_x) - longint'(p.ax)) * n[0]
            + (longint'(eye_y) - longint'(p.ay)) * n[1]
            + (longint'(eye_z) - longint'(p.az)) * n[2];
        res.vis = dot > 0;
        res.degen = 1'b0;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0)
        begin
            res.nx = '0;
            res.ny = '0;
            res.nz = '0;
            res.vis = 1'b0;
            res.degen = 1'b1;
            return res;
        end
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (n[i] < 0) ? longint'(-n[i]) : n[i];
            if (mag[i] > mx)
                mx = mag[i];
        end
        s = 0;
        while (s < 63 && (mx >> s) >= (64'd1 << 30))
            s++;
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] >>= s;
            len2 += mag[i] * mag[i];
        end
        r = int_sqrt(len2);
        if (r == 0)
            r = 1;
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << nbc_pkg::NORMAL_FRAC_BITS) + (r >> 1)) / r;
            if (q > (64'd1 << nbc_pkg::NORMAL_FRAC_BITS))
                q = 64'd1 << nbc_pkg::NORMAL_FRAC_BITS;
            if (n[i] < 0)
                q = -q;
            o[i] = q[NW-1:0];
        end
        res.nx = o[0];
        res.ny = o[1];
        res.nz = o[2];
        return res;
    endfunction

    // Driver: presents queued polygons with random idle bursts unless no_idle is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            {first_x, first_y, first_z} <= '0;
            {second_x, second_y, second_z} <= '0;
            {third_x, third_y, third_z} <= '0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
                cull_expected.push_back(cull_predict(cur_poly));
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (polys_pending.size() > 0 && !no_idle && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(0, 9);
                start <= 1'b0;
            end
            else if (polys_pending.size() > 0)
            begin
                cur_poly = polys_pending.pop_front();
                first_x <= cur_poly.ax;
                first_y <= cur_poly.ay;
                first_z <= cur_poly.az;
                second_x <= cur_poly.bx;
                second_y <= cur_poly.by;
                second_z <= cur_poly.bz;
                third_x <= cur_poly.cx;
                third_y <= cur_poly.cy;
                third_z <= cur_poly.cz;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (cull_expected.size() == 0)
            begin
                $error("result with no transaction outstanding");
                n_errors++;
            end
            else
            begin
                cull_t e;
                e = cull_expected.pop_front();
                if (normal_x !== e.nx)
                begin
                    $error("normal_x expected %0d got %0d", e.nx, normal_x);
                    n_errors++;
                end
                if (normal_y !== e.ny)
                begin
                    $error("normal_y expected %0d got %0d", e.ny, normal_y);
                    n_errors++;
                end
                if (normal_z !== e.nz)
                begin
                    $error("normal_z expected %0d got %0d", e.nz, normal_z);
                    n_errors++;
                end
                if (visible !== e.vis)
                begin
                    $error("visible expected %0d got %0d", e.vis, visible);
                    n_errors++;
                end
                if (degenerate !== e.degen)
                begin
                    $error("degenerate expected %0d got %0d", e.degen, degenerate);
                    n_errors++;
                end
            end
        end
    end

    task automatic add_poly(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
                            coord_t bz, coord_t cx, coord_t cy, coord_t cz);
        poly_t p;
        p.ax = ax; p.ay = ay; p.az = az;
        p.bx = bx; p.by = by; p.bz = bz;
        p.cx = cx; p.cy = cy; p.cz = cz;
        polys_pending.push_back(p);
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    // Random polygons: full range, small local triangles, collinear and coincident, vertex at the eye
    task automatic add_random(int count);
        coord_t ax, ay, az;
        int span, t, kind;
        for (int k = 0; k < count; k++)
        begin
            kind = $urandom_range(0, 9);
            ax = rand_coord(); ay = rand_coord(); az = rand_coord();
            if (kind < 4)
                add_poly(ax, ay, az, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord());
            else if (kind < 8)
            begin
                span = 1 << $urandom_range(0, 10);
                add_poly(ax, ay, az,
                         ax + coord_t'($urandom_range(0, 2 * span) - span),
                         ay + coord_t'($urandom_range(0, 2 * span) - span),
                         az + coord_t'($urandom_range(0, 2 * span) - span),
                         ax + coord_t'($urandom_range(0, 2 * span) - span),
                         ay + coord_t'($urandom_range(0, 2 * span) - span),
                         az + coord_t'($urandom_range(0, 2 * span) - span));
            end
            else if (kind == 8)
            begin
                // third vertex on the line through the first two
                t = $urandom_range(0, 4) - 2;
                span = $urandom_range(0, 200) - 100;
                add_poly(ax, ay, az, ax + coord_t'(span), ay + coord_t'(2 * span),
                         az - coord_t'(span), ax + coord_t'(t * span),
                         ay + coord_t'(2 * t * span), az - coord_t'(t * span));
            end
            else
                add_poly(eye_x, eye_y, eye_z, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic wait_idle();
        while (polys_pending.size() > 0 || start || cull_expected.size() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, coord_t val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            nbc_pkg::REG_VIEW_X: eye_x = val;
            nbc_pkg::REG_VIEW_Y: eye_y = val;
            nbc_pkg::REG_VIEW_Z: eye_z = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_view(coord_t x, coord_t y, coord_t z);
        write_view_regs:
        begin
            write_reg(nbc_pkg::REG_VIEW_X, x);
            write_reg(nbc_pkg::REG_VIEW_Y, y);
            write_reg(nbc_pkg::REG_VIEW_Z, z);
        end
    endtask

    // Sequencer: reset, directed polygons, then view-point phases
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = nbc_pkg::REG_VIEW_X;
        cfg_data = '0;
        eye_x = '0; eye_y = '0; eye_z = '0;
        no_idle = 1'b0;
        n_errors = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: degenerate, axis unit normals, extremes, facing both ways
        add_poly(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_poly(16, 16, 16, 16, 16, 16, 16, 16, 16);
        add_poly(0, 0, 0, 32, 64, 96, 64, 128, 192);
        add_poly(0, 0, -16, 16, 0, -16, 0, 16, -16);
        add_poly(0, 0, -16, 0, 16, -16, 16, 0, -16);
        add_poly(-16, 0, 0, -16, 16, 0, -16, 0, 16);
        add_poly(0, 16, 0, 0, 16, 16, 16, 16, 0);
        add_poly(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
        add_poly(-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        add_poly(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, -32768);
        add_poly(-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768);
        add_poly(0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_poly(0, 0, 0, 1, 1, 0, 0, 0, 1);
        add_poly(0, 0, 0, 3, 4, 0, -4, 3, 5);
        add_poly(0, 0, 0, 1, 2, 3, 2, 4, 6);
        add_poly(32767, 0, 0, 0, 32767, 0, 0, 0, 32767);
        add_poly(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);
        add_poly(5, -7, 11, 32767, -32768, 1, -32768, 32767, -1);
        add_random(80);
        wait_idle();

        write_view(-32768, -32768, -32768);
        write_reg(REG_NONE, 16'h7fff);
        add_poly(-32768, -32768, -32768, 0, 0, 16, 16, 0, 0);
        add_random(100);
        // hold off until the pipeline has drained
        while (polys_pending.size() > 0 || cull_expected.size() > 0 || start)
            @(posedge clk);
        add_random(60);
        wait_idle();

        write_view(32767, 32767, 32767);
        add_random(150);
        wait_idle();

        write_view(rand_coord(), rand_coord(), rand_coord());
        add_random(150);
        wait_idle();

        write_view(0, 32767, -32768);
        no_idle = 1'b1;
        add_random(140);
        wait_idle();

        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule
